// ----- src/positional_list_store_defines.svh -----
// ----------------------------------------------------------------------------
// positional_list_store_defines
// Assertion macros for the positional list store. The bodies expect clk and
// arst_n in scope and compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

`ifndef SYNTHESIS
// a condition that must hold at every clock edge out of reset
`define PLS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// a same-cycle implication
`define PLS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// a next-cycle implication
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PLS_ASSERT_ALWAYS(lbl, cond, msg)
`define PLS_ASSERT_IMPL(lbl, ante, cons, msg)
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/pls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and codes of the positional list store: item formats,
// operation and status codes, controller command and status bundles.
// ----------------------------------------------------------------------------
package pls_pkg;

	// field widths
	localparam int OP_W    = 2;
	localparam int IDX_W   = 9;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 2;

	// store depth default and capacity reset value
	localparam int MAX_ENTRIES_DEF = 256;
	localparam logic [IDX_W-1:0] CAP_RESET = 9'd256;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_GET    = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	// request item
	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [IDX_W-1:0]  position;
		logic [DATA_W-1:0] item_value;
	} req_item_t;

	// result item
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [DATA_W-1:0] read_value;
		logic [IDX_W-1:0]  count;
	} rsp_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;     // latch the request and decode it
		logic rd_up;    // read cursor-1, move it to cursor, step cursor down
		logic rd_pos;   // read the entry at the position
		logic capture;  // keep the read data as the result value
		logic rd_dn;    // read cursor, move it to cursor-1, step cursor up
		logic wr_new;   // write the new value at the position
		logic finish;   // load the result register and commit the count
	} pls_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [OP_W-1:0] dec_op;   // operation of the incoming item
		logic            dec_ok;   // incoming item will succeed
		logic            up_more;  // entries left to shift up
		logic            dn_more;  // entries left to shift down
		logic            out_busy; // result register full and stalled
	} pls_sts_t;

endpackage

// ----- src/pls_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_datapath
// Entry store, fill count, capacity register, shift cursor and the result
// register. Moves entries one per cycle under the controller's commands.
// ----------------------------------------------------------------------------
module pls_datapath #(
	parameter int MAX_ENTRIES = pls_pkg::MAX_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pls_pkg::req_item_t           req_item,
	input  logic                         cfg_wr_en,
	input  logic [pls_pkg::IDX_W-1:0]    cfg_wr_data,
	input  pls_pkg::pls_cmd_t            cmd,
	output pls_pkg::pls_sts_t            sts,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output pls_pkg::rsp_item_t           rsp_item
);
	import pls_pkg::*;

	localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned MaxEnt = MAX_ENTRIES;

	// entry store
	logic [DATA_W-1:0] mem [MAX_ENTRIES];

	logic [IDX_W-1:0]  fill_q;
	logic [IDX_W-1:0]  cap_q;
	logic [OP_W-1:0]   op_q;
	logic [IDX_W-1:0]  pos_q;
	logic [DATA_W-1:0] val_q;
	logic [STAT_W-1:0] status_q;
	logic [DATA_W-1:0] rv_q;
	logic [IDX_W-1:0]  cursor_q;
	logic [DATA_W-1:0] rd_data_q;
	logic              pend_s1;
	logic [ADDR_W-1:0] pend_addr_s1;
	logic              rsp_valid_q;
	rsp_item_t         rsp_item_q;

	logic              full;
	logic [STAT_W-1:0] dec_status;
	logic [IDX_W-1:0]  pos_eff;
	logic [IDX_W-1:0]  cursor_init;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_idx;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic [IDX_W-1:0]  fill_next;

	// decode of the incoming item against the current fill
	always_comb begin
		full = (32'(fill_q) >= 32'(cap_q)) || (32'(fill_q) >= MaxEnt);
		dec_status = ST_OK;
		case (req_item.operation)
			OP_INSERT: if (full) dec_status = ST_FULL;
			OP_GET, OP_DELETE: if (req_item.position >= fill_q) dec_status = ST_RANGE;
			default: dec_status = ST_OK;
		endcase
		pos_eff = req_item.position;
		if (req_item.operation == OP_INSERT && req_item.position > fill_q)
			pos_eff = fill_q;
		cursor_init = (req_item.operation == OP_INSERT) ? fill_q
			: req_item.position + IDX_W'(1);
	end

	assign sts.dec_op   = req_item.operation;
	assign sts.dec_ok   = (dec_status == ST_OK);
	assign sts.up_more  = (cursor_q > pos_q);
	assign sts.dn_more  = (cursor_q < fill_q);
	assign sts.out_busy = rsp_valid_q && rsp_stall;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// request latch and shift cursor
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= req_item.operation;
			pos_q    <= pos_eff;
			val_q    <= req_item.item_value;
			status_q <= dec_status;
			cursor_q <= cursor_init;
		end else if (cmd.rd_up) begin
			cursor_q <= cursor_q - IDX_W'(1);
		end else if (cmd.rd_dn) begin
			cursor_q <= cursor_q + IDX_W'(1);
		end
	end

	// result value
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rv_q <= '0;
		end else if (cmd.capture) begin
			rv_q <= rd_data_q;
		end
	end

	// read port select
	always_comb begin
		rd_en  = cmd.rd_up || cmd.rd_pos || cmd.rd_dn;
		rd_idx = pos_q;
		if (cmd.rd_up)
			rd_idx = cursor_q - IDX_W'(1);
		else if (cmd.rd_dn)
			rd_idx = cursor_q;
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[ADDR_W'(rd_idx)];
		end
	end

	// pending move: the word read last cycle lands one place over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= cmd.rd_up || cmd.rd_dn;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_up) begin
			pend_addr_s1 <= ADDR_W'(cursor_q);
		end else if (cmd.rd_dn) begin
			pend_addr_s1 <= ADDR_W'(cursor_q - IDX_W'(1));
		end
	end

	// write port select
	always_comb begin
		wr_en   = pend_s1 || cmd.wr_new;
		wr_addr = pend_s1 ? pend_addr_s1 : ADDR_W'(pos_q);
		wr_data = pend_s1 ? rd_data_q : val_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// count after the operation
	always_comb begin
		fill_next = fill_q;
		case (op_q)
			OP_INSERT: if (status_q == ST_OK) fill_next = fill_q + IDX_W'(1);
			OP_DELETE: if (status_q == ST_OK) fill_next = fill_q - IDX_W'(1);
			OP_CLEAR:  fill_next = '0;
			default:   fill_next = fill_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.finish) begin
			fill_q <= fill_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_item_q.status     <= status_q;
			rsp_item_q.read_value <= rv_q;
			rsp_item_q.count      <= fill_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

endmodule

// ----- src/pls_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_ctrl
// Sequencer of the positional list store: takes one item, steps the
// datapath through its reads and shifts, then hands over the result.
// ----------------------------------------------------------------------------
module pls_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  pls_pkg::pls_sts_t    sts,
	output pls_pkg::pls_cmd_t    cmd
);
	import pls_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UP   = 3'd1;
	localparam logic [2:0] S_INS  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_CAP  = 3'd4;
	localparam logic [2:0] S_DN   = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0]      state_q;
	logic [2:0]      state_d;
	logic [OP_W-1:0] op_q;

	assign req_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					if (!sts.dec_ok || sts.dec_op == OP_CLEAR)
						state_d = S_FIN;
					else if (sts.dec_op == OP_INSERT)
						state_d = S_UP;
					else
						state_d = S_RD;
				end
			end
			S_UP: begin
				if (sts.up_more)
					cmd.rd_up = 1'b1;
				else
					state_d = S_INS;
			end
			S_INS: begin
				cmd.wr_new = 1'b1;
				state_d    = S_FIN;
			end
			S_RD: begin
				cmd.rd_pos = 1'b1;
				state_d    = S_CAP;
			end
			S_CAP: begin
				cmd.capture = 1'b1;
				state_d     = (op_q == OP_DELETE) ? S_DN : S_FIN;
			end
			S_DN: begin
				if (sts.dn_more)
					cmd.rd_dn = 1'b1;
				else
					state_d = S_FIN;
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and operation registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_INSERT;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				op_q <= sts.dec_op;
		end
	end

endmodule

// ----- src/positional_list_store.sv -----
`timescale 1ns / 1ps
// Operation: one item at a time; no new item is taken until the result register is loaded,
// and a stalled result holds the sequencer. An insert past the end appends. Insert and delete
// shift entries one word per cycle through the store's single read and write port.
// Reset: arst_n clears fill to 0 and capacity to 256 at once; the store is not cleared.
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of 32-bit values kept packed in an on-chip store, with
// insert, get, delete and clear at a position and a configurable capacity.
// ----------------------------------------------------------------------------
`include "positional_list_store_defines.svh"

module positional_list_store #(
	parameter int MAX_ENTRIES = pls_pkg::MAX_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  pls_pkg::req_item_t           req_item,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output pls_pkg::rsp_item_t           rsp_item,
	input  logic                         cfg_wr_en,
	input  logic [pls_pkg::IDX_W-1:0]    cfg_wr_data
);
	import pls_pkg::*;

	localparam int unsigned MaxEnt = MAX_ENTRIES;

	pls_cmd_t cmd;
	pls_sts_t sts;

	// sequencer
	pls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// store and result path
	pls_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_item    (req_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp_item    (rsp_item)
	);

	// checks
	`PLS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
		"no stall after accepted item")
	`PLS_ASSERT_IMPL(a_refused_no_value, rsp_valid && rsp_item.status != ST_OK,
		rsp_item.read_value == '0, "refused item carries a value")
	`PLS_ASSERT_IMPL(a_count_in_store, rsp_valid, 32'(rsp_item.count) <= MaxEnt,
		"count beyond store depth")
	`PLS_ASSERT_IMPL(a_result_from_work, $rose(rsp_valid), $past(req_stall),
		"result without an item in work")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for positional_list_store. A mirror of the list
// predicts every result, and a checker compares each delivered result, field
// by field, with the oldest prediction. Directed items cover the empty list,
// the head, the tail, appends, zero values, clear and the capacity limits.
// One long output hold-off that backs the block up comes next, then random
// phases at several capacities, with bursty input and a shifting stall pattern.
// ----------------------------------------------------------------------------
module tb_top;
	import pls_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int TAIL_CYCLES = 300;
	localparam int PRINT_LIMIT = 30;
	localparam int HOLD_CYCLES = 400;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_item_t         req_item = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_item_t         rsp_item;
	logic              cfg_wr_en = 1'b0;
	logic [IDX_W-1:0]  cfg_wr_data = '0;

	// mirror of the list and its setting
	logic [DATA_W-1:0] list_mem [MAX_ENTRIES_DEF];
	int unsigned       list_fill = 0;
	int unsigned       list_cap = 32'(CAP_RESET);
	rsp_item_t         expected_rsp [$];
	rsp_item_t         want_rsp;

	// run statistics
	int          n_errors = 0;
	int          n_checked = 0;
	int          n_cycles = 0;
	int          n_by_op [4] = '{0, 0, 0, 0};
	int          n_full = 0;
	int          n_range = 0;
	int          n_cap_writes = 0;
	int unsigned peak_fill = 0;
	bit          backed_up = 1'b0;

	// sender and receiver pacing
	int burst_left = 0;
	bit gaps_on = 1'b1;
	int hold_left = 0;
	int stall_pct = 0;
	int stall_window = 0;

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	positional_list_store #(
		.MAX_ENTRIES(MAX_ENTRIES_DEF)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_item   (req_item),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_item   (rsp_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// run limit
	always @(posedge clk) begin
		n_cycles = n_cycles + 1;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", n_cycles,
				expected_rsp.size());
			$display("positional_list_store regression: fail");
			$finish;
		end
	end

	// receiver: stall rate changes per window, long hold when one is pending
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			if (stall_window == 0) begin
				stall_window = $urandom_range(16, 96);
				case ($urandom_range(4))
					0, 1: stall_pct = 0;
					2: stall_pct = 20;
					3: stall_pct = 45;
					default: stall_pct = 75;
				endcase
			end
			stall_window = stall_window - 1;
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		n_errors++;
		// keep the log short once the run is known bad
		if (n_errors <= PRINT_LIMIT)
			$display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
				n_checked, what, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("result with none pending", rsp_item.read_value, '0);
			end else begin
				want_rsp = expected_rsp.pop_front();
				n_checked++;
				if (rsp_item.status !== want_rsp.status)
					report_mismatch("status", DATA_W'(rsp_item.status),
						DATA_W'(want_rsp.status));
				if (rsp_item.read_value !== want_rsp.read_value)
					report_mismatch("read_value", rsp_item.read_value, want_rsp.read_value);
				if (rsp_item.count !== want_rsp.count)
					report_mismatch("count", DATA_W'(rsp_item.count),
						DATA_W'(want_rsp.count));
			end
		end
		if (hold_left > 0 && req_valid && req_stall === 1'b1)
			backed_up = 1'b1;
	end

	// apply one request to the mirror and return the result it must give
	function automatic rsp_item_t apply_list_op(input req_item_t it);
		rsp_item_t   r;
		int unsigned lim;
		int unsigned p;
		int unsigned i;
		r = '0;
		r.status = ST_OK;
		lim = (list_cap < MAX_ENTRIES_DEF) ? list_cap : MAX_ENTRIES_DEF;
		p = 32'(it.position);
		n_by_op[it.operation]++;
		case (it.operation)
			OP_INSERT: begin
				if (list_fill >= lim) begin
					r.status = ST_FULL;
				end else begin
					// past the end appends; later entries move up
					if (p > list_fill)
						p = list_fill;
					for (i = list_fill; i > p; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[p] = it.item_value;
					list_fill++;
				end
			end
			OP_GET: begin
				if (p >= list_fill)
					r.status = ST_RANGE;
				else
					r.read_value = list_mem[p];
			end
			OP_DELETE: begin
				if (p >= list_fill) begin
					r.status = ST_RANGE;
				end else begin
					r.read_value = list_mem[p];
					for (i = p + 1; i < list_fill; i++)
						list_mem[i - 1] = list_mem[i];
					list_fill--;
				end
			end
			default: list_fill = 0;
		endcase
		if (r.status == ST_FULL)
			n_full++;
		if (r.status == ST_RANGE)
			n_range++;
		if (list_fill > peak_fill)
			peak_fill = list_fill;
		r.count = IDX_W'(list_fill);
		return r;
	endfunction

	// offer one item and wait for it to be taken
	task automatic send_req(input req_item_t it);
		@(negedge clk);
		req_valid <= 1'b1;
		req_item <= it;
		do @(posedge clk); while (req_stall !== 1'b0);
		expected_rsp.push_back(apply_list_op(it));
	endtask

	// sender in bursts, with gaps between them while gaps_on is set
	task automatic offer_req(input req_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (gaps_on) begin
				gap = $urandom_range(1, 6);
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		send_req(it);
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		burst_left = 0;
		while (expected_rsp.size() != 0) @(posedge clk);
	endtask

	// capacity is written only with nothing in flight
	task automatic set_capacity(input int unsigned cap);
		drain_results();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= IDX_W'(cap);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		list_cap = cap;
		n_cap_writes++;
	endtask

	function automatic req_item_t make_req(input logic [OP_W-1:0] op,
			input int unsigned pos, input logic [DATA_W-1:0] val);
		req_item_t it;
		it.operation = op;
		it.position = IDX_W'(pos);
		it.item_value = val;
		return it;
	endfunction

	function automatic logic [OP_W-1:0] pick_op(input int w_ins, input int w_get,
			input int w_del);
		int r;
		r = $urandom_range(99);
		if (r < w_ins)
			return OP_INSERT;
		if (r < w_ins + w_get)
			return OP_GET;
		if (r < w_ins + w_get + w_del)
			return OP_DELETE;
		return OP_CLEAR;
	endfunction

	// mostly positions inside the list, with head, tail and past-end cases
	function automatic logic [IDX_W-1:0] pick_position(input logic [OP_W-1:0] op);
		int unsigned top;
		top = (op == OP_INSERT) ? list_fill : list_fill - 1;
		if (list_fill == 0 && op != OP_INSERT)
			return IDX_W'($urandom_range(511));
		case ($urandom_range(19))
			0, 1, 2: return IDX_W'($urandom_range(511));
			3: return '0;
			4: return IDX_W'(top);
			default: return IDX_W'($urandom_range(top));
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(19))
			0, 1: return '0;
			2: return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic req_item_t random_req(input int w_ins, input int w_get,
			input int w_del);
		logic [OP_W-1:0] op;
		op = pick_op(w_ins, w_get, w_del);
		return make_req(op, 32'(pick_position(op)), pick_value());
	endfunction

	// requests on an empty list touch nothing
	task automatic test_empty_list();
		send_req(make_req(OP_GET, 0, 32'h0));
		send_req(make_req(OP_DELETE, 0, 32'hFFFF_FFFF));
		send_req(make_req(OP_DELETE, 511, 32'h0));
		send_req(make_req(OP_GET, 256, 32'h0));
		send_req(make_req(OP_CLEAR, 511, 32'hFFFF_FFFF));
	endtask

	// head, middle and tail inserts, zero values, reads and removals
	task automatic test_insert_get_delete();
		send_req(make_req(OP_INSERT, 0, 32'h0));
		send_req(make_req(OP_INSERT, 511, 32'hFFFF_FFFF));
		send_req(make_req(OP_INSERT, 1, 32'h1234_5678));
		send_req(make_req(OP_INSERT, 0, 32'hA5A5_A5A5));
		send_req(make_req(OP_GET, 0, 32'h0));
		send_req(make_req(OP_GET, 3, 32'h0));
		send_req(make_req(OP_GET, 4, 32'h0));
		send_req(make_req(OP_GET, 256, 32'h0));
		// the stored zero is a real entry
		send_req(make_req(OP_DELETE, 1, 32'h0));
		send_req(make_req(OP_DELETE, 2, 32'h0));
		send_req(make_req(OP_DELETE, 3, 32'h0));
		send_req(make_req(OP_GET, 1, 32'h0));
		send_req(make_req(OP_CLEAR, 0, 32'h0));
		send_req(make_req(OP_GET, 0, 32'h0));
	endtask

	// zero capacity, a full list, and capacity lowered below the count
	task automatic test_capacity_limits();
		set_capacity(0);
		send_req(make_req(OP_INSERT, 0, 32'h5555_5555));
		set_capacity(2);
		send_req(make_req(OP_INSERT, 0, 32'h0000_0001));
		send_req(make_req(OP_INSERT, 9, 32'h8000_0000));
		send_req(make_req(OP_INSERT, 0, 32'hDEAD_BEEF));
		set_capacity(1);
		send_req(make_req(OP_GET, 1, 32'h0));
		send_req(make_req(OP_INSERT, 1, 32'h0BAD_F00D));
		send_req(make_req(OP_DELETE, 0, 32'h0));
		send_req(make_req(OP_DELETE, 0, 32'h0));
		send_req(make_req(OP_INSERT, 0, 32'h7777_0000));
	endtask

	// random phases, each at its own capacity and operation mix
	task automatic test_random_phases();
		int ph;
		int k;
		int n_items;
		int w_ins;
		int w_get;
		int w_del;
		int unsigned cap;
		for (ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin cap = 256; n_items = 330; w_ins = 85; w_get = 10; w_del = 5; end
				1: begin cap = 40;  n_items = 150; w_ins = 30; w_get = 30; w_del = 37; end
				2: begin cap = 255; n_items = 120; w_ins = 40; w_get = 25; w_del = 30; end
				3: begin cap = 8;   n_items = 120; w_ins = 45; w_get = 25; w_del = 25; end
				4: begin cap = 1;   n_items = 60;  w_ins = 40; w_get = 30; w_del = 25; end
				5: begin cap = 0;   n_items = 25;  w_ins = 40; w_get = 30; w_del = 25; end
				default: begin
					cap = $urandom_range(2, 200);
					n_items = 100; w_ins = 40; w_get = 30; w_del = 25;
				end
			endcase
			set_capacity(cap);
			gaps_on = (ph % 3 != 1);
			for (k = 0; k < n_items; k++)
				offer_req(random_req(w_ins, w_get, w_del));
		end
		gaps_on = 1'b1;
	endtask

	// receiver holds off while the sender keeps offering items
	task automatic test_result_backpressure();
		int k;
		set_capacity(256);
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		gaps_on = 1'b0;
		for (k = 0; k < 16; k++)
			offer_req(random_req(50, 30, 20));
		gaps_on = 1'b1;
		drain_results();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_insert_get_delete();
		test_capacity_limits();
		test_result_backpressure();
		test_random_phases();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d insert, %0d get, %0d delete, %0d clear items; %0d checked",
			n_by_op[OP_INSERT], n_by_op[OP_GET], n_by_op[OP_DELETE], n_by_op[OP_CLEAR],
			n_checked);
		$display("%0d full, %0d out of range, peak count %0d, %0d capacity writes, %s %0d",
			n_full, n_range, peak_fill, n_cap_writes, "input backed up:", backed_up);
		if (n_errors == 0 && expected_rsp.size() == 0) begin
			$display("positional_list_store regression: pass");
		end else begin
			$display("positional_list_store regression: fail");
		end
		$finish;
	end

endmodule
